FILE: rtl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types and constants for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int CHANNEL_BITS_DEFAULT = 8;
    localparam int PIX_BITS             = 8;
    localparam int HUE_BITS             = 13;
    localparam int SAT_BITS             = 16;
    localparam int BRIGHT_BITS          = 8;

    // quotient bits per divide lane, one per cell
    localparam int QUO_BITS     = 16;
    // hue quotient never exceeds one sextant (1024)
    localparam int HUE_QUO_BITS = 11;
    localparam int HUE_SHIFT    = 10;

    localparam logic [HUE_BITS-1:0] HUE_ZERO  = 13'd0;
    localparam logic [HUE_BITS-1:0] HUE_GREEN = 13'd2048;
    localparam logic [HUE_BITS-1:0] HUE_BLUE  = 13'd4096;
    localparam logic [HUE_BITS-1:0] HUE_TURN  = 13'd6144;

    typedef enum logic [2:0] {
        SEC_RED   = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_BLUE  = 3'b100
    } sector_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] red;
        logic [PIX_BITS-1:0] green;
        logic [PIX_BITS-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [HUE_BITS-1:0]    hue;
        logic [SAT_BITS-1:0]    saturation;
        logic [BRIGHT_BITS-1:0] brightness;
    } hsv_t;

    typedef struct packed {
        sector_t                sector;
        logic                   neg;
        logic                   dzero;
        logic                   mzero;
        logic [BRIGHT_BITS-1:0] bright;
    } side_t;

endpackage

FILE: rtl/rgbhsv_front.sv
// ----------------------------------------------------------------------------
// rgbhsv_front
// Max/min search, sector pick and divider setup; one register stage.
// ----------------------------------------------------------------------------
module rgbhsv_front #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                pix_valid,
    input  rgbhsv_pkg::rgb_t                    pix,
    output logic                                vld,
    output rgbhsv_pkg::side_t                   side,
    output logic [CHANNEL_BITS-1:0]             rem_h,
    output logic [CHANNEL_BITS-1:0]             rem_s,
    output logic [CHANNEL_BITS-1:0]             div_h,
    output logic [CHANNEL_BITS-1:0]             div_s,
    output logic [rgbhsv_pkg::QUO_BITS-1:0]     word_h,
    output logic [rgbhsv_pkg::QUO_BITS-1:0]     word_s
);
    import rgbhsv_pkg::*;

    localparam int NUM_BITS = CHANNEL_BITS + QUO_BITS;

    logic [CHANNEL_BITS-1:0] r, g, b, mx, mn, delta, op_a, op_b, mag;
    logic [NUM_BITS-1:0]     num_h, num_s;
    sector_t                 sec;
    side_t                   side_next;

    logic                    vld_reg;
    side_t                   side_reg;
    logic [CHANNEL_BITS-1:0] rem_h_reg, rem_s_reg, div_h_reg, div_s_reg;
    logic [QUO_BITS-1:0]     word_h_reg, word_s_reg;

    always_comb
    begin
        r = CHANNEL_BITS'(pix.red);
        g = CHANNEL_BITS'(pix.green);
        b = CHANNEL_BITS'(pix.blue);
        mx = r;
        mn = r;
        if (g > mx)
        begin
            mx = g;
        end
        if (b > mx)
        begin
            mx = b;
        end
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
        delta = mx - mn;

        if (mx == r)
        begin
            sec  = SEC_RED;
            op_a = g;
            op_b = b;
        end
        else if (mx == g)
        begin
            sec  = SEC_GREEN;
            op_a = b;
            op_b = r;
        end
        else
        begin
            sec  = SEC_BLUE;
            op_a = r;
            op_b = g;
        end
        mag = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);

        num_h = NUM_BITS'(mag) << HUE_SHIFT;
        num_s = (NUM_BITS'(delta) << QUO_BITS) - NUM_BITS'(delta);

        side_next.sector = sec;
        side_next.neg    = (op_a < op_b);
        side_next.dzero  = (delta == '0);
        side_next.mzero  = (mx == '0);
        side_next.bright = BRIGHT_BITS'(mx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg   <= side_next;
            rem_h_reg  <= num_h[NUM_BITS-1:QUO_BITS];
            rem_s_reg  <= num_s[NUM_BITS-1:QUO_BITS];
            word_h_reg <= num_h[QUO_BITS-1:0];
            word_s_reg <= num_s[QUO_BITS-1:0];
            div_h_reg  <= delta;
            div_s_reg  <= mx;
        end
    end

    assign vld    = vld_reg;
    assign side   = side_reg;
    assign rem_h  = rem_h_reg;
    assign rem_s  = rem_s_reg;
    assign div_h  = div_h_reg;
    assign div_s  = div_s_reg;
    assign word_h = word_h_reg;
    assign word_s = word_s_reg;

endmodule

FILE: rtl/rgbhsv_cell.sv
// ----------------------------------------------------------------------------
// rgbhsv_cell
// One restoring-divide step for the hue and saturation lanes.
// ----------------------------------------------------------------------------
module rgbhsv_cell #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                vld_in,
    input  rgbhsv_pkg::side_t                   side_in,
    input  logic [CHANNEL_BITS-1:0]             rem_h_in,
    input  logic [CHANNEL_BITS-1:0]             rem_s_in,
    input  logic [CHANNEL_BITS-1:0]             div_h_in,
    input  logic [CHANNEL_BITS-1:0]             div_s_in,
    input  logic [rgbhsv_pkg::QUO_BITS-1:0]     word_h_in,
    input  logic [rgbhsv_pkg::QUO_BITS-1:0]     word_s_in,
    output logic                                vld_out,
    output rgbhsv_pkg::side_t                   side_out,
    output logic [CHANNEL_BITS-1:0]             rem_h_out,
    output logic [CHANNEL_BITS-1:0]             rem_s_out,
    output logic [CHANNEL_BITS-1:0]             div_h_out,
    output logic [CHANNEL_BITS-1:0]             div_s_out,
    output logic [rgbhsv_pkg::QUO_BITS-1:0]     word_h_out,
    output logic [rgbhsv_pkg::QUO_BITS-1:0]     word_s_out
);
    import rgbhsv_pkg::*;

    // word: numerator bits shift out at the top, quotient bits shift in below
    logic [CHANNEL_BITS:0]   trial_h, trial_s, sub_h, sub_s;
    logic                    ge_h, ge_s;
    logic [CHANNEL_BITS-1:0] rem_h_next, rem_s_next;
    logic [QUO_BITS-1:0]     word_h_next, word_s_next;

    logic                    vld_reg;
    side_t                   side_reg;
    logic [CHANNEL_BITS-1:0] rem_h_reg, rem_s_reg, div_h_reg, div_s_reg;
    logic [QUO_BITS-1:0]     word_h_reg, word_s_reg;

    always_comb
    begin
        trial_h = {rem_h_in, word_h_in[QUO_BITS-1]};
        trial_s = {rem_s_in, word_s_in[QUO_BITS-1]};
        sub_h   = trial_h - {1'b0, div_h_in};
        sub_s   = trial_s - {1'b0, div_s_in};
        ge_h    = (trial_h >= {1'b0, div_h_in});
        ge_s    = (trial_s >= {1'b0, div_s_in});
        rem_h_next  = ge_h ? sub_h[CHANNEL_BITS-1:0] : trial_h[CHANNEL_BITS-1:0];
        rem_s_next  = ge_s ? sub_s[CHANNEL_BITS-1:0] : trial_s[CHANNEL_BITS-1:0];
        word_h_next = {word_h_in[QUO_BITS-2:0], ge_h};
        word_s_next = {word_s_in[QUO_BITS-2:0], ge_s};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg   <= side_in;
            rem_h_reg  <= rem_h_next;
            rem_s_reg  <= rem_s_next;
            word_h_reg <= word_h_next;
            word_s_reg <= word_s_next;
            div_h_reg  <= div_h_in;
            div_s_reg  <= div_s_in;
        end
    end

    assign vld_out    = vld_reg;
    assign side_out   = side_reg;
    assign rem_h_out  = rem_h_reg;
    assign rem_s_out  = rem_s_reg;
    assign div_h_out  = div_h_reg;
    assign div_s_out  = div_s_reg;
    assign word_h_out = word_h_reg;
    assign word_s_out = word_s_reg;

endmodule

FILE: rtl/rgbhsv_back.sv
// ----------------------------------------------------------------------------
// rgbhsv_back
// Hue assembly with floor rounding and wrap; output register.
// ----------------------------------------------------------------------------
module rgbhsv_back #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                vld_in,
    input  rgbhsv_pkg::side_t                   side_in,
    input  logic [CHANNEL_BITS-1:0]             rem_h_in,
    input  logic [rgbhsv_pkg::QUO_BITS-1:0]     word_h_in,
    input  logic [rgbhsv_pkg::QUO_BITS-1:0]     word_s_in,
    output logic                                hsv_valid,
    output rgbhsv_pkg::hsv_t                    hsv
);
    import rgbhsv_pkg::*;

    logic [HUE_BITS-1:0] base, quo, hue_raw;
    hsv_t                hsv_next;
    logic                vld_reg;
    hsv_t                hsv_reg;

    always_comb
    begin
        case (side_in.sector)
            SEC_RED:   base = side_in.neg ? HUE_TURN : HUE_ZERO;
            SEC_GREEN: base = HUE_GREEN;
            SEC_BLUE:  base = HUE_BLUE;
            default:   base = HUE_ZERO;
        endcase
        // floor of a negative quotient rounds the magnitude up
        quo = HUE_BITS'(word_h_in[HUE_QUO_BITS-1:0])
            + HUE_BITS'(side_in.neg && (rem_h_in != '0));
        hue_raw = side_in.neg ? (base - quo) : (base + quo);

        hsv_next.hue        = side_in.dzero ? HUE_ZERO : hue_raw;
        hsv_next.saturation = side_in.mzero ? '0 : word_s_in;
        hsv_next.brightness = side_in.bright;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hsv_reg <= hsv_next;
        end
    end

    assign hsv_valid = vld_reg;
    assign hsv       = hsv_reg;

endmodule

FILE: rtl/rgb_to_hsv_convert_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_top
// RGB pixel to hue / saturation / brightness converter.
//
// Input channel rgb: rgb_valid, rgb_stall, rgb (red, green, blue). A
// transaction is taken at a clock edge with rgb_valid high, rgb_stall low.
// Output channel hsv: hsv_valid, hsv_stall, hsv (hue, saturation,
// brightness), same handshake, one result per input pixel, in order.
// Throughput: one pixel per clock while hsv_stall does not hold the pipeline. From
// the accepting edge to hsv_valid a pixel passes 18 register stages: one setup
// stage loaded at the accepting edge, one cell per quotient bit = 16 cells, one
// output stage. The 16-cell divide chain makes up most of that depth.
// Stall: the whole pipeline advances together. While hsv_valid is high and
// hsv_stall is high, everything holds and rgb_stall is raised; empty slots
// keep filling otherwise. rgb_stall depends combinationally on hsv_stall.
// Reset: all valid flags clear; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_top #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rgb_valid,
    output logic              rgb_stall,
    input  rgbhsv_pkg::rgb_t  rgb,
    output logic              hsv_valid,
    input  logic              hsv_stall,
    output rgbhsv_pkg::hsv_t  hsv
);
    import rgbhsv_pkg::*;

    localparam int STEPS = QUO_BITS;

    logic                    adv;
    logic                    vld    [0:STEPS];
    side_t                   side   [0:STEPS];
    logic [CHANNEL_BITS-1:0] rem_h  [0:STEPS];
    logic [CHANNEL_BITS-1:0] rem_s  [0:STEPS];
    logic [CHANNEL_BITS-1:0] div_h  [0:STEPS];
    logic [CHANNEL_BITS-1:0] div_s  [0:STEPS];
    logic [QUO_BITS-1:0]     word_h [0:STEPS];
    logic [QUO_BITS-1:0]     word_s [0:STEPS];

    assign adv       = !hsv_valid || !hsv_stall;
    assign rgb_stall = !adv;

    rgbhsv_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .pix_valid (rgb_valid),
        .pix       (rgb),
        .vld       (vld[0]),
        .side      (side[0]),
        .rem_h     (rem_h[0]),
        .rem_s     (rem_s[0]),
        .div_h     (div_h[0]),
        .div_s     (div_s[0]),
        .word_h    (word_h[0]),
        .word_s    (word_s[0])
    );

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        rgbhsv_cell #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .vld_in     (vld[i]),
            .side_in    (side[i]),
            .rem_h_in   (rem_h[i]),
            .rem_s_in   (rem_s[i]),
            .div_h_in   (div_h[i]),
            .div_s_in   (div_s[i]),
            .word_h_in  (word_h[i]),
            .word_s_in  (word_s[i]),
            .vld_out    (vld[i+1]),
            .side_out   (side[i+1]),
            .rem_h_out  (rem_h[i+1]),
            .rem_s_out  (rem_s[i+1]),
            .div_h_out  (div_h[i+1]),
            .div_s_out  (div_s[i+1]),
            .word_h_out (word_h[i+1]),
            .word_s_out (word_s[i+1])
        );
    end

    rgbhsv_back #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .vld_in    (vld[STEPS]),
        .side_in   (side[STEPS]),
        .rem_h_in  (rem_h[STEPS]),
        .word_h_in (word_h[STEPS]),
        .word_s_in (word_s[STEPS]),
        .hsv_valid (hsv_valid),
        .hsv       (hsv)
    );

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> (hsv.hue < HUE_TURN))
        else $error("hue out of range");

    a_hue_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && (hsv.hue != HUE_ZERO)) |-> (hsv.saturation != '0))
        else $error("nonzero hue with zero saturation");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid && !rgb_stall) |=> vld[0])
        else $error("accepted pixel lost at setup stage");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && hsv_stall) |-> rgb_stall)
        else $error("input taken while output held");

endmodule

FILE: tb/sv/rgb_hsv_checker.sv
// ----------------------------------------------------------------------------
// rgb_hsv_checker
// Watches the rgb and hsv channels of the converter. For every accepted pixel
// it computes the expected hue, saturation and brightness, queues it, and
// compares each accepted hsv transaction against the oldest queued entry.
// ----------------------------------------------------------------------------
module rgb_hsv_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rgb_valid,
    input  logic             rgb_stall,
    input  rgbhsv_pkg::rgb_t rgb,
    input  logic             hsv_valid,
    input  logic             hsv_stall,
    input  rgbhsv_pkg::hsv_t hsv,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rgbhsv_pkg::*;

    hsv_t hsv_expected_q[$];
    int   fail_count = 0;
    int   pending_count = 0;

    assign errors  = fail_count;
    assign pending = pending_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic hsv_t hsv_of(input rgb_t px);
        hsv_t res;
        int   r;
        int   g;
        int   b;
        int   mx;
        int   mn;
        int   delta;
        int   diff;
        int   base;
        int   num;
        int   quo;
        int   hue;
        r     = int'(px.red);
        g     = int'(px.green);
        b     = int'(px.blue);
        mx    = r;
        mn    = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        hue   = 0;
        if (delta != 0)
        begin
            if (mx == r)
            begin
                diff = g - b;
                base = int'(HUE_ZERO);
            end
            else if (mx == g)
            begin
                diff = b - r;
                base = int'(HUE_GREEN);
            end
            else
            begin
                diff = r - g;
                base = int'(HUE_BLUE);
            end
            num = diff * (1 << HUE_SHIFT);
            // floor division, rounds toward minus infinity
            if (num >= 0)
                quo = num / delta;
            else
                quo = -((-num + delta - 1) / delta);
            hue = base + quo;
            if (hue < 0)
                hue += int'(HUE_TURN);
        end
        res.hue        = hue[HUE_BITS-1:0];
        res.saturation = (mx != 0) ? SAT_BITS'((delta * 65535) / mx) : '0;
        res.brightness = mx[BRIGHT_BITS-1:0];
        return res;
    endfunction

    always @(posedge clk)
    begin
        hsv_t want;
        if (rst_n)
        begin
            if (hsv_valid && !hsv_stall)
            begin
                if (hsv_expected_q.size() == 0)
                begin
                    $display("%0t unexpected hsv transaction: hue %0d sat %0d bright %0d",
                             $realtime, hsv.hue, hsv.saturation, hsv.brightness);
                    fail_count++;
                end
                else
                begin
                    want = hsv_expected_q.pop_front();
                    if (hsv.hue !== want.hue)
                        report_mismatch("hue", int'(hsv.hue), int'(want.hue));
                    if (hsv.saturation !== want.saturation)
                        report_mismatch("saturation", int'(hsv.saturation),
                                        int'(want.saturation));
                    if (hsv.brightness !== want.brightness)
                        report_mismatch("brightness", int'(hsv.brightness),
                                        int'(want.brightness));
                end
            end
            if (rgb_valid && !rgb_stall)
                hsv_expected_q.push_back(hsv_of(rgb));
            pending_count <= hsv_expected_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for rgb_to_hsv_convert_top: a directed set of corner pixels
// (black, white, grays, pure colors, ties, red-sector wrap) followed by
// random pixels, with random gaps on the sender and random stalls on the
// receiver. Checking is done by rgb_hsv_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rgbhsv_pkg::*;

    localparam int NUM_RANDOM = 700;
    localparam int DRAIN_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic rgb_valid = 1'b0;
    logic rgb_stall;
    rgb_t rgb = '0;
    logic hsv_valid;
    logic hsv_stall = 1'b0;
    hsv_t hsv;
    int   errors;
    int   pending;
    bit   no_gaps = 1'b0;

    always #10 clk = ~clk;

    rgb_to_hsv_convert_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb       (rgb),
        .hsv_valid (hsv_valid),
        .hsv_stall (hsv_stall),
        .hsv       (hsv)
    );

    rgb_hsv_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb       (rgb),
        .hsv_valid (hsv_valid),
        .hsv_stall (hsv_stall),
        .hsv       (hsv),
        .errors    (errors),
        .pending   (pending)
    );

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            rgb_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rgb_valid <= 1'b1;
        rgb       <= '{red: r, green: g, blue: b};
        do
            @(posedge clk);
        while (rgb_stall);
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_random_pixel();
        logic [7:0] a;
        logic [7:0] c;
        int         kind;
        a    = 8'($urandom);
        c    = 8'($urandom);
        kind = $urandom_range(0, 9);
        case (kind)
            0: send_pixel(a, a, a);
            1: send_pixel(a, a, c);
            2: send_pixel(c, a, a);
            3: send_pixel(a, c, a);
            4: send_pixel(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                          8'($urandom_range(0, 3)));
            5: send_pixel(8'($urandom_range(250, 255)), 8'($urandom_range(250, 255)),
                          8'($urandom_range(0, 255)));
            default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        endcase
    endtask

    // receiver: random stall before each transaction
    initial
    begin
        int n;
        @(posedge clk iff rst_n);
        forever
        begin
            n = no_gaps ? 0 : $urandom_range(0, 6);
            if (n > 0)
            begin
                hsv_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            hsv_stall <= 1'b0;
            do
                @(posedge clk);
            while (!hsv_valid);
        end
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd254);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd254, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd254);
        send_pixel(8'd254, 8'd0, 8'd255);
        send_pixel(8'd200, 8'd100, 8'd50);
        send_pixel(8'd10, 8'd20, 8'd30);
        send_pixel(8'd1, 8'd2, 8'd3);
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd255);
        send_pixel(8'd170, 8'd85, 8'd170);

        // hold off until the pipeline has emptied
        rgb_valid <= 1'b0;
        @(posedge clk);
        wait_drained();

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 60 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            send_random_pixel();
        end
        rgb_valid <= 1'b0;
        no_gaps = 1'b0;

        @(posedge clk);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
